>>> rtl/graph_reachability_closure_top_macros.svh
// Assertion macros shared by the RTL of the reachability closure block.
`ifndef GRAPH_REACHABILITY_CLOSURE_TOP_MACROS_SVH
`define GRAPH_REACHABILITY_CLOSURE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/grc_pkg.sv
// Package: types and constants of the reachability closure block.
package grc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int ROW_W        = MAX_VERTICES;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int VTX_W        = 5;
	localparam int KIND_W       = 3;
	localparam int CFG_W        = 6;
	localparam int CNT_W        = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD     = 3'd0,
		KIND_REMOVE  = 3'd1,
		KIND_QEDGE   = 3'd2,
		KIND_CLOSURE = 3'd3,
		KIND_QREACH  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SET,
		CELL_CLR,
		CELL_COPY,
		CELL_PIVOT
	} cell_op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VTX_W-1:0]  vertex_a;
		logic [VTX_W-1:0]  vertex_b;
	} in_item_t;

	typedef struct packed {
		logic answer;
		logic index_error;
	} out_item_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t          op;
		logic [VTX_W-1:0]  vertex_a;
		logic [VTX_W-1:0]  vertex_b;
		logic [IDX_W-1:0]  piv_idx;
		logic [ROW_W-1:0]  piv_row;
		logic [ROW_W-1:0]  row_mask;
	} cell_ctl_t;

endpackage

>>> rtl/grc_cell.sv
// One vertex cell: holds an adjacency row, a reachability row and a pivot token.
module grc_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  grc_pkg::cell_ctl_t      ctl,
	input  logic [grc_pkg::IDX_W-1:0] idx,
	input  logic                    live,
	input  logic                    tok_in,
	output logic                    tok_out,
	output logic [grc_pkg::ROW_W-1:0] adj_row,
	output logic [grc_pkg::ROW_W-1:0] reach_row,
	output logic [grc_pkg::ROW_W-1:0] drive_row
);
	import grc_pkg::*;

	logic [ROW_W-1:0] adj_q;
	logic [ROW_W-1:0] reach_q;
	logic             tok_q;
	logic             hit_a;
	logic             hit_b;
	logic [ROW_W-1:0] edge_bits;

	assign hit_a = (idx == IDX_W'(ctl.vertex_a));
	assign hit_b = (idx == IDX_W'(ctl.vertex_b));

	// symmetric edge: row a gets bit b, row b gets bit a
	always_comb begin
		edge_bits = '0;
		if (hit_a)
			edge_bits = edge_bits | (ROW_W'(1) << IDX_W'(ctl.vertex_b));
		if (hit_b)
			edge_bits = edge_bits | (ROW_W'(1) << IDX_W'(ctl.vertex_a));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_q   <= '0;
			reach_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_SET: begin
					adj_q <= adj_q | edge_bits;
				end
				CELL_CLR: begin
					adj_q <= adj_q & ~edge_bits;
				end
				CELL_COPY: begin
					reach_q <= live ? (adj_q & ctl.row_mask) : '0;
				end
				CELL_PIVOT: begin
					if (reach_q[ctl.piv_idx])
						reach_q <= reach_q | ctl.piv_row;
				end
				default: begin
				end
			endcase
			// token walks one cell per pivot step, dropped otherwise
			tok_q <= ((ctl.op == CELL_COPY) || (ctl.op == CELL_PIVOT)) ? tok_in : 1'b0;
		end
	end

	assign tok_out   = tok_q;
	assign adj_row   = adj_q;
	assign reach_row = reach_q;
	assign drive_row = tok_q ? reach_q : '0;

endmodule

>>> rtl/graph_reachability_closure_top.sv
// Top level of the reachability closure block: controller and row of vertex cells.
//
// Usage: commands arrive on the in channel (in_valid/in_stall, payload in_data),
// one result per command leaves on the out channel (out_valid/out_stall, out_data).
// A transfer happens at a rising edge with valid high and stall low.
// Edge add/remove/query and reachability query: result is registered and shows in
// the cycle after the input transfer; a new command may follow every cycle unless
// a result is stalled. Closure: the transfer edge copies adjacency into the reach
// rows, then one pivot step per live vertex (n = min(vertex_count, 32)) runs, all
// cells updating in parallel from the pivot row; the result is registered after
// the last pivot step (at the transfer when n is zero) and in_stall is high during
// the pivot steps. Closure throughput is set by the single pivot row bus: one
// pivot per cycle. Reachability queries see the matrix of the last closure.
// cfg_wr_en/cfg_wr_data write vertex_count; write only while the block is idle.
// Reset (arst_n low) clears both matrices, sets vertex_count to 32 and empties
// the output register. A stalled result stays in the output register; the input
// side then takes a new command only in the cycle the result is taken.
`include "graph_reachability_closure_top_macros.svh"

module graph_reachability_closure_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  grc_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output grc_pkg::out_item_t         out_data,
	input  logic                       cfg_wr_en,
	input  logic [grc_pkg::CFG_W-1:0]  cfg_wr_data
);
	import grc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_PIVOT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] piv_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic [CFG_W-1:0] vertex_count_q;

	logic [CNT_W-1:0] vc_ext;
	logic [CNT_W-1:0] n_ext;
	logic [ROW_W-1:0] row_mask;
	logic             in_xfer;
	logic             out_xfer;
	logic             bad_idx;
	logic             err;
	logic             ans;
	logic             last_pivot;
	cell_op_t         op;
	cell_ctl_t        ctl;
	logic [IDX_W-1:0] ra;
	logic [IDX_W-1:0] rb;
	logic [ROW_W-1:0] piv_row;

	logic [MAX_VERTICES-1:0] tok;
	logic [MAX_VERTICES-1:0] tok_in;
	logic [ROW_W-1:0]        adj_rows   [MAX_VERTICES];
	logic [ROW_W-1:0]        reach_rows [MAX_VERTICES];
	logic [ROW_W-1:0]        drive_rows [MAX_VERTICES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vertex_count_q <= CFG_W'(32);
		else if (cfg_wr_en)
			vertex_count_q <= cfg_wr_data;
	end

	// live count saturates at the cell count
	assign vc_ext = CNT_W'(vertex_count_q);
	assign n_ext  = (vc_ext > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_ext;

	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++)
			row_mask[j] = (CNT_W'(j) < n_ext);
	end

	assign out_xfer = out_valid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	assign bad_idx = (CNT_W'(in_data.vertex_a) >= n_ext) || (CNT_W'(in_data.vertex_b) >= n_ext);
	assign ra      = IDX_W'(in_data.vertex_a);
	assign rb      = IDX_W'(in_data.vertex_b);

	always_comb begin
		err = 1'b0;
		ans = 1'b0;
		op  = CELL_HOLD;
		case (kind_t'(in_data.kind))
			KIND_ADD: begin
				err = bad_idx;
				if (in_xfer && !bad_idx)
					op = CELL_SET;
			end
			KIND_REMOVE: begin
				err = bad_idx;
				if (in_xfer && !bad_idx)
					op = CELL_CLR;
			end
			KIND_QEDGE: begin
				err = bad_idx;
				ans = !bad_idx && adj_rows[ra][rb];
			end
			KIND_QREACH: begin
				err = bad_idx;
				ans = !bad_idx && reach_rows[ra][rb];
			end
			KIND_CLOSURE: begin
				if (in_xfer)
					op = CELL_COPY;
			end
			default: begin
			end
		endcase
		if (state_q == ST_PIVOT)
			op = CELL_PIVOT;
	end

	// pivot row: only the token cell drives a nonzero row
	always_comb begin
		piv_row = '0;
		for (int i = 0; i < MAX_VERTICES; i++)
			piv_row = piv_row | drive_rows[i];
	end

	assign ctl.op       = op;
	assign ctl.vertex_a = in_data.vertex_a;
	assign ctl.vertex_b = in_data.vertex_b;
	assign ctl.piv_idx  = piv_q;
	assign ctl.piv_row  = piv_row;
	assign ctl.row_mask = row_mask;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign tok_in[gi] = (op == CELL_COPY);
			end else begin : g_link
				// token only moves on pivot steps; a new closure restarts it at the head
				assign tok_in[gi] = tok[gi-1] && (op == CELL_PIVOT);
			end
			grc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.idx       (IDX_W'(gi)),
				.live      (row_mask[gi]),
				.tok_in    (tok_in[gi]),
				.tok_out   (tok[gi]),
				.adj_row   (adj_rows[gi]),
				.reach_row (reach_rows[gi]),
				.drive_row (drive_rows[gi])
			);
		end
	endgenerate

	assign last_pivot = ((CNT_W'(piv_q) + CNT_W'(1)) == n_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			piv_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_xfer)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (kind_t'(in_data.kind) == KIND_CLOSURE && n_ext != '0) begin
							state_q <= ST_PIVOT;
							piv_q   <= '0;
						end else begin
							out_valid_q       <= 1'b1;
							out_q.answer      <= ans;
							out_q.index_error <= err;
						end
					end
				end
				ST_PIVOT: begin
					if (last_pivot) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_q       <= '0;
					end else begin
						piv_q <= piv_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`GRC_ASSERT_NOW(a_one_token, clk, arst_n, 1'b1, $onehot0(tok), "more than one pivot token")
	`GRC_ASSERT_NOW(a_pivot_token, clk, arst_n, state_q == ST_PIVOT, $onehot(tok), "pivot step without a token")
	`GRC_ASSERT_NOW(a_pivot_range, clk, arst_n, state_q == ST_PIVOT, CNT_W'(piv_q) < n_ext, "pivot index past live count")
	`GRC_ASSERT_NEXT(a_closure_start, clk, arst_n, in_xfer && kind_t'(in_data.kind) == KIND_CLOSURE && n_ext != '0, state_q == ST_PIVOT && !out_valid_q, "closure did not start pivoting")

endmodule
